/* design/isc_pkg.sv */
// ----------------------------------------------------------------------------
// isc_pkg
// Shared types and constants for the insertion sort counter.
// ----------------------------------------------------------------------------
package isc_pkg;

    localparam int MAX_ENTRIES_DEF = 1024;

    localparam int ELEM_W   = 32;
    localparam int CMP_W    = 20;
    localparam int IDX_W    = 10;
    localparam int STORED_W = 11;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;

    localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RDWAIT,
        S_FINISH
    } state_t;

    // compare unit result
    typedef struct packed {
        logic             less;
        logic [CMP_W-1:0] total;
    } cmp_res_t;

endpackage

/* design/isc_ram.sv */
// ----------------------------------------------------------------------------
// isc_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/isc_cmp_unit.sv */
// ----------------------------------------------------------------------------
// isc_cmp_unit
// Shared compare step: signed less-than and saturating compare count.
// ----------------------------------------------------------------------------
module isc_cmp_unit (
    input  logic signed [isc_pkg::ELEM_W-1:0] value,
    input  logic        [isc_pkg::ELEM_W-1:0] stored_elem,
    input  logic        [isc_pkg::CMP_W-1:0]  total,
    output isc_pkg::cmp_res_t                 res
);

    always_comb
    begin
        res.less  = value < $signed(stored_elem);
        // saturate at all ones
        res.total = (total == isc_pkg::CMP_MAX) ? total : total + 1'b1;
    end

endmodule

/* design/insertion_sort_counter_top.sv */
// ----------------------------------------------------------------------------
// insertion_sort_counter_top
// Online insertion sorter with a saturating comparison counter.
// ----------------------------------------------------------------------------
// One item is taken at a time; in_stall stays high from acceptance until the
// result is loaded into the output register. An insert into a store that is
// not full compares one stored element per cycle (and moves it up one place
// if it is greater) with the single compare unit, walking down from the top
// of the store through the one-write/one-read RAM. A read waits in S_RDWAIT
// for the registered RAM read unless the index is not below the count; a
// clear or an unused code goes straight to S_FINISH. A finished result sits
// in the output register while the next item is accepted; only the end of
// that item waits for the register to drain. Reset needs no clearing pass:
// the element count bounds every read of the store.
// ----------------------------------------------------------------------------
module insertion_sort_counter_top #(
    parameter int MAX_ENTRIES = isc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic        [isc_pkg::CMD_W-1:0]      cmd,
    input  logic signed [isc_pkg::ELEM_W-1:0]     value,
    input  logic        [isc_pkg::IDX_W-1:0]      index,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [isc_pkg::ELEM_W-1:0]     element,
    output logic        [isc_pkg::CMP_W-1:0]      comparisons,
    output logic        [isc_pkg::STORED_W-1:0]   stored,
    output logic        [isc_pkg::STATUS_W-1:0]   status
);

    // AW: RAM address, CW: count/position (holds MAX_ENTRIES itself),
    // XW: common width for range checks on the index
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > isc_pkg::IDX_W) ? CW : isc_pkg::IDX_W;

    isc_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                    count_reg, count_next;
    logic [isc_pkg::CMP_W-1:0]        cmp_reg, cmp_next;
    logic [CW-1:0]                    pos_reg, pos_next;
    logic signed [isc_pkg::ELEM_W-1:0] value_reg, value_next;
    logic [isc_pkg::ELEM_W-1:0]       elem_res_reg, elem_res_next;
    logic [isc_pkg::STATUS_W-1:0]     status_res_reg, status_res_next;

    logic                             out_valid_reg, out_valid_next;
    logic [isc_pkg::ELEM_W-1:0]       out_element_reg, out_element_next;
    logic [isc_pkg::CMP_W-1:0]        out_cmp_reg, out_cmp_next;
    logic [isc_pkg::STORED_W-1:0]     out_stored_reg, out_stored_next;
    logic [isc_pkg::STATUS_W-1:0]     out_status_reg, out_status_next;

    // RAM port
    logic                             wr_en;
    logic [AW-1:0]                    wr_addr;
    logic [isc_pkg::ELEM_W-1:0]       wr_data;
    logic [AW-1:0]                    rd_addr;
    logic [isc_pkg::ELEM_W-1:0]       rd_data;

    isc_pkg::cmp_res_t                cmp_res;

    logic                             in_acc;
    logic                             out_free;
    logic                             full;
    logic                             rd_ok;
    logic                             pos_zero;
    logic [CW-1:0]                    count_m1;
    logic [CW-1:0]                    pos_m1;
    logic [CW-1:0]                    pos_m2;
    logic [XW-1:0]                    idx_x;
    logic [XW-1:0]                    cnt_x;

    assign in_stall = (state_reg != isc_pkg::S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    assign full     = (count_reg == CW'(MAX_ENTRIES));
    assign pos_zero = (pos_reg == '0);
    assign count_m1 = count_reg - CW'(1);
    assign pos_m1   = pos_reg - CW'(1);
    assign pos_m2   = pos_reg - CW'(2);
    assign idx_x    = XW'(index);
    assign cnt_x    = XW'(count_reg);
    assign rd_ok    = (idx_x < cnt_x) && (idx_x < XW'(MAX_ENTRIES));

    isc_ram #(
        .WIDTH (isc_pkg::ELEM_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    isc_cmp_unit u_cmp (
        .value       (value_reg),
        .stored_elem (rd_data),
        .total       (cmp_reg),
        .res         (cmp_res)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            isc_pkg::S_IDLE:
            begin
                if (in_acc)
                begin
                    if (cmd == isc_pkg::CMD_INSERT)
                    begin
                        state_next = full ? isc_pkg::S_FINISH : isc_pkg::S_SCAN;
                    end
                    else if (cmd == isc_pkg::CMD_READ)
                    begin
                        state_next = rd_ok ? isc_pkg::S_RDWAIT : isc_pkg::S_FINISH;
                    end
                    else
                    begin
                        state_next = isc_pkg::S_FINISH;
                    end
                end
            end
            isc_pkg::S_SCAN:
            begin
                if (pos_zero || !cmp_res.less)
                begin
                    state_next = isc_pkg::S_FINISH;
                end
            end
            isc_pkg::S_RDWAIT:
            begin
                state_next = isc_pkg::S_FINISH;
            end
            isc_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = isc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = isc_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------- datapath and outputs ----------------
    always_comb
    begin
        count_next      = count_reg;
        cmp_next        = cmp_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        elem_res_next   = elem_res_reg;
        status_res_next = status_res_reg;

        out_valid_next   = out_valid_reg && out_stall;
        out_element_next = out_element_reg;
        out_cmp_next     = out_cmp_reg;
        out_stored_next  = out_stored_reg;
        out_status_next  = out_status_reg;

        wr_en   = 1'b0;
        wr_addr = pos_reg[AW-1:0];
        wr_data = value_reg;
        rd_addr = count_m1[AW-1:0];

        case (state_reg)
            isc_pkg::S_IDLE:
            begin
                // prefetch: top element for an insert, the index for a read
                if (cmd == isc_pkg::CMD_READ)
                begin
                    rd_addr = idx_x[AW-1:0];
                end
                if (in_acc)
                begin
                    value_next      = value;
                    pos_next        = count_reg;
                    elem_res_next   = '0;
                    status_res_next = isc_pkg::ST_OK;
                    if (cmd == isc_pkg::CMD_INSERT)
                    begin
                        if (full)
                        begin
                            status_res_next = isc_pkg::ST_FULL;
                        end
                    end
                    else if (cmd == isc_pkg::CMD_READ)
                    begin
                        if (!rd_ok)
                        begin
                            status_res_next = isc_pkg::ST_RANGE;
                        end
                    end
                    else if (cmd == isc_pkg::CMD_CLEAR)
                    begin
                        count_next = '0;
                        cmp_next   = '0;
                    end
                end
            end
            isc_pkg::S_SCAN:
            begin
                // rd_data holds the element just below pos
                rd_addr = pos_m2[AW-1:0];
                wr_en   = 1'b1;
                if (pos_zero)
                begin
                    count_next = count_reg + CW'(1);
                end
                else
                begin
                    cmp_next = cmp_res.total;
                    if (cmp_res.less)
                    begin
                        wr_data  = rd_data;
                        pos_next = pos_m1;
                    end
                    else
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            isc_pkg::S_RDWAIT:
            begin
                elem_res_next = rd_data;
            end
            isc_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_element_next = elem_res_reg;
                    out_cmp_next     = cmp_reg;
                    out_stored_next  = isc_pkg::STORED_W'(count_reg);
                    out_status_next  = status_res_reg;
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= isc_pkg::S_IDLE;
            count_reg     <= '0;
            cmp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_reg       <= cmp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        value_reg       <= value_next;
        elem_res_reg    <= elem_res_next;
        status_res_reg  <= status_res_next;
        out_element_reg <= out_element_next;
        out_cmp_reg     <= out_cmp_next;
        out_stored_reg  <= out_stored_next;
        out_status_reg  <= out_status_next;
    end

    assign out_valid   = out_valid_reg;
    assign element     = $signed(out_element_reg);
    assign comparisons = out_cmp_reg;
    assign stored      = out_stored_reg;
    assign status      = out_status_reg;

    // ---------------- assertions ----------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_ENTRIES))
        else $error("element count above capacity");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == isc_pkg::S_SCAN) |-> (pos_reg <= count_reg))
        else $error("scan position above element count");

    a_wr_only_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == isc_pkg::S_SCAN))
        else $error("store written outside scan");

    a_cmp_drop_on_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmp_reg < $past(cmp_reg)) |-> $past(in_acc && (cmd == isc_pkg::CMD_CLEAR)))
        else $error("comparison total fell without clear");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == isc_pkg::S_FINISH))
        else $error("result published outside finish");

endmodule

/* verif/insertion_sort_counter_checker.sv */
// ----------------------------------------------------------------------------
// insertion_sort_counter_checker
// Watches both channels of the insertion sort counter. Every accepted item
// runs through a local copy of the sorted store, and the result it must give
// is queued. Every accepted result is compared field by field against the
// oldest queued one. Mismatches and the number of results still awaited go
// to the testbench top.
// ----------------------------------------------------------------------------
module insertion_sort_counter_checker #(
    parameter int MAX_ENTRIES = isc_pkg::MAX_ENTRIES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic        [isc_pkg::CMD_W-1:0]      cmd,
    input  logic signed [isc_pkg::ELEM_W-1:0]     value,
    input  logic        [isc_pkg::IDX_W-1:0]      index,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [isc_pkg::ELEM_W-1:0]     element,
    input  logic        [isc_pkg::CMP_W-1:0]      comparisons,
    input  logic        [isc_pkg::STORED_W-1:0]   stored,
    input  logic        [isc_pkg::STATUS_W-1:0]   status,
    output int                                    mismatches,
    output int                                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import isc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [ELEM_W-1:0]   element;
        logic        [CMP_W-1:0]    comparisons;
        logic        [STORED_W-1:0] stored;
        logic        [STATUS_W-1:0] status;
    } sort_result_t;

    // local image of the block's state
    logic signed [ELEM_W-1:0] sorted_vals [MAX_ENTRIES];
    int                       held;
    logic        [CMP_W-1:0]  compare_total;

    sort_result_t awaited_results [$];
    int           result_num;

    // saturating compare count
    function automatic void count_compare();
        if (compare_total != CMP_MAX)
            compare_total = compare_total + 1'b1;
    endfunction

    // applies one command to the local store, returns the result it yields
    function automatic sort_result_t apply_command(
        input logic        [CMD_W-1:0]  c,
        input logic signed [ELEM_W-1:0] v,
        input logic        [IDX_W-1:0]  ix
    );
        sort_result_t r;
        int           pos;
        bit           settled;
        r = '0;
        r.status = ST_OK;
        case (c)
            CMD_INSERT:
            begin
                if (held >= MAX_ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    // walk down from the top; the stopping compare counts too
                    pos = held;
                    settled = 1'b0;
                    while (pos > 0 && !settled)
                    begin
                        count_compare();
                        if (v < sorted_vals[pos-1])
                        begin
                            sorted_vals[pos] = sorted_vals[pos-1];
                            pos--;
                        end
                        else
                            settled = 1'b1;
                    end
                    sorted_vals[pos] = v;
                    held++;
                end
            end
            CMD_READ:
            begin
                if (ix < held)
                    r.element = sorted_vals[ix];
                else
                    r.status = ST_RANGE;
            end
            CMD_CLEAR:
            begin
                held = 0;
                compare_total = '0;
            end
            default:
                ;   // spare code: no effect
        endcase
        r.comparisons = compare_total;
        r.stored = STORED_W'(held);
        return r;
    endfunction

    task automatic check_field(
        input string       field,
        input logic [31:0] want,
        input logic [31:0] got
    );
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%m: result %0d %s expected %h got %h",
                         result_num, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sort_result_t want;
        if (!rst_n)
        begin
            held = 0;
            compare_total = '0;
            awaited_results.delete();
            result_num = 0;
            mismatches = 0;
            outstanding = 0;
        end
        else
        begin
            // a result can never belong to an item taken at the same edge
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%m: result %0d arrived with none awaited", result_num);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("element", want.element, element);
                    check_field("comparisons", want.comparisons, comparisons);
                    check_field("stored", want.stored, stored);
                    check_field("status", want.status, status);
                end
                result_num++;
            end
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_command(cmd, value, index));
            outstanding = awaited_results.size();
        end
    end

endmodule

/* verif/insertion_sort_counter_top_tb.sv */
// ----------------------------------------------------------------------------
// insertion_sort_counter_top_tb
// Drives commands into the insertion sort counter and gives the verdict.
// A short directed run covers the edges, then random command streams in
// three idle profiles, then one fill of the whole store to reach the full
// case. Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
module insertion_sort_counter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import isc_pkg::*;

    localparam int ENTRIES      = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 580;
    // watchdog limit, set far above the slowest honest run
    localparam int CYCLE_LIMIT  = 1_000_000;
    // extra wait after the last awaited result, to catch strays
    localparam int DRAIN_CYCLES = 64;

    // the one command code the block ignores
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic        [CMD_W-1:0]    cmd;
    logic signed [ELEM_W-1:0]   value;
    logic        [IDX_W-1:0]    index;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [ELEM_W-1:0]   element;
    logic        [CMP_W-1:0]    comparisons;
    logic        [STORED_W-1:0] stored;
    logic        [STATUS_W-1:0] status;

    int mismatches;
    int outstanding;
    int cycle_count;

    // idle profile, changed between phases (percent of cycles)
    int send_gap_pct;
    int recv_stall_pct;

    // stimulus bookkeeping only: how full the store should be, and the size
    // at which the random stream clears it again
    int fill_level;
    int level_cap;

    insertion_sort_counter_top #(
        .MAX_ENTRIES (ENTRIES)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .value       (value),
        .index       (index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element     (element),
        .comparisons (comparisons),
        .stored      (stored),
        .status      (status)
    );

    insertion_sort_counter_checker #(
        .MAX_ENTRIES (ENTRIES)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cmd         (cmd),
        .value       (value),
        .index       (index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .element     (element),
        .comparisons (comparisons),
        .stored      (stored),
        .status      (status),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run here.
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("insertion_sort_counter_top_tb: errors");
            $finish;
        end
    end

    // Receiver back-pressure: one fresh draw per cycle, at the falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // Called just after a falling edge; returns just after the falling edge
    // that follows acceptance. Valid is only dropped inside the gap loop, so
    // back-to-back items keep it high without a same-step low/high pair.
    task automatic send_item(
        input logic        [CMD_W-1:0]  c,
        input logic signed [ELEM_W-1:0] v,
        input logic        [IDX_W-1:0]  ix
    );
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        value    <= v;
        index    <= ix;
        // stall is sampled before the block updates it at this edge
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Value mix: full-range noise, a narrow band that forces ties, the
    // extremes, and a moderate band around zero.
    function automatic logic signed [ELEM_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40)
            return $urandom;
        else if (roll < 70)
            return $signed($urandom_range(16)) - 8;
        else if (roll < 85)
        begin
            case ($urandom_range(4))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return -32'sd1;
                3:       return 32'sd1;
                default: return 32'sd0;
            endcase
        end
        else
            return $signed($urandom_range(2000)) - 1000;
    endfunction

    // New clear threshold: mostly small stores, now and then 100 to 250.
    function automatic int pick_cap();
        if ($urandom_range(9) == 0)
            return $urandom_range(250, 100);
        return $urandom_range(40, 1);
    endfunction

    // Random stream: runs of inserts with reads mixed in, cleared whenever
    // the store reaches its threshold, plus stray clears and spare codes.
    // Unused fields of each command carry noise.
    task automatic random_stream(input int n);
        int k;
        int roll;
        for (k = 0; k < n; k++)
        begin
            roll = $urandom_range(99);
            if (fill_level >= level_cap || roll < 4)
            begin
                send_item(CMD_CLEAR, $urandom, $urandom);
                fill_level = 0;
                level_cap  = pick_cap();
            end
            else if (roll < 8)
                send_item(CMD_SPARE, $urandom, $urandom);
            else if (roll < 62)
            begin
                send_item(CMD_INSERT, pick_value(), $urandom);
                fill_level++;
            end
            else if (fill_level > 0 && $urandom_range(99) < 85)
                send_item(CMD_READ, $urandom, IDX_W'($urandom_range(fill_level - 1)));
            else
                // anywhere in the index space, mostly past the count
                send_item(CMD_READ, $urandom, $urandom);
        end
    endtask

    // One pass up to a full store. Values climb with a little jitter so most
    // inserts stop after a compare or two; a handful of random values walk
    // far down. Then inserts are refused and the top entry is read back.
    task automatic fill_to_capacity();
        int k;
        logic signed [ELEM_W-1:0] v;
        send_item(CMD_CLEAR, $urandom, $urandom);
        for (k = 0; k < ENTRIES; k++)
        begin
            if (k % 128 == 77)
                v = pick_value();
            else
                v = 32'sh8000_0000 + k * 4096 + $urandom_range(6000);
            send_item(CMD_INSERT, v, $urandom);
        end
        // full store: refused, nothing moves
        send_item(CMD_INSERT, 32'sh8000_0000, $urandom);
        send_item(CMD_INSERT, 32'sh7fff_ffff, $urandom);
        send_item(CMD_INSERT, pick_value(), $urandom);
        send_item(CMD_READ, $urandom, IDX_W'(ENTRIES - 1));
        send_item(CMD_READ, $urandom, '0);
        for (k = 0; k < 6; k++)
            send_item(CMD_READ, $urandom, $urandom);
        send_item(CMD_CLEAR, $urandom, $urandom);
        fill_level = 0;
    endtask

    initial
    begin
        int k;

        // every input known from time zero
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        out_stall      = 1'b0;
        cmd            = CMD_INSERT;
        value          = '0;
        index          = '0;
        send_gap_pct   = 37;
        recv_stall_pct = 74;
        fill_level     = 0;
        level_cap      = pick_cap();

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed edges (sender 37% idle, receiver 74% stalled) ----
        // empty store: read refused; first insert needs no compare
        send_item(CMD_READ, 32'sd0, '0);
        send_item(CMD_INSERT, 32'sd0, '1);
        // spare code changes nothing, whatever the other fields hold
        send_item(CMD_SPARE, 32'sh7fff_ffff, '1);
        send_item(CMD_INSERT, 32'sh7fff_ffff, '0);
        // most negative value walks to the bottom
        send_item(CMD_INSERT, 32'sh8000_0000, '0);
        send_item(CMD_INSERT, -32'sd1, '0);
        // tie with the earlier zero: scan stops at the equal element
        send_item(CMD_INSERT, 32'sd0, '0);
        send_item(CMD_INSERT, 32'sd1, '0);
        for (k = 0; k < 6; k++)
            send_item(CMD_READ, '1, IDX_W'(k));
        // index equal to the count, and the top of the index space
        send_item(CMD_READ, '0, IDX_W'(6));
        send_item(CMD_READ, '0, '1);
        send_item(CMD_SPARE, '0, '0);
        send_item(CMD_CLEAR, '1, '1);
        // after a clear the old contents are gone
        send_item(CMD_READ, '0, '0);
        send_item(CMD_INSERT, 32'sh8000_0000, '0);
        send_item(CMD_INSERT, 32'sh8000_0000, '0);
        send_item(CMD_CLEAR, '0, '0);

        // ---- random streams over three idle profiles ----
        random_stream(RANDOM_ITEMS / 3);

        send_gap_pct   = 74;
        recv_stall_pct = 37;
        random_stream(RANDOM_ITEMS / 3);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        random_stream(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

        // ---- whole store; the count cannot reach saturation at this size ----
        fill_to_capacity();
        random_stream(24);

        in_valid <= 1'b0;

        // let every awaited result arrive, then watch for strays
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("insertion_sort_counter_top_tb: clean");
        else
            $display("insertion_sort_counter_top_tb: errors");
        $finish;
    end

endmodule
